// ===== hdl/sobel_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude block.
// Used by the controller, datapath and top level; no dependencies.
package sobel_pkg;
  localparam int MaxWidth   = 2048;
  localparam int MaxHeight  = 2048;
  localparam int AddrW      = $clog2(MaxWidth);
  localparam int CntW       = 11;
  localparam int SizeW      = 12;
  localparam int EnergyW    = 17;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef enum logic [2:0] {
    StIdle, StRead, StCalc, StRoot, StOut
  } state_e;

  typedef struct packed {
    logic load;      // capture input beat and start store read
    logic calc;      // compute gradients, update stores and window
    logic root_start;
    logic root_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;      // current pixel yields a result
    logic root_done;
  } sts_t;
endpackage

// ===== hdl/sobel_datapath.sv =====
// Datapath: line stores, 3x3 window, counters, gradient and bit-serial root.
// Depends on sobel_pkg; driven by sobel_ctrl through cmd_t / sts_t.
module sobel_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sobel_pkg::cmd_t               cmd_i,
  output sobel_pkg::sts_t               sts_o,
  input  logic [7:0]                    pixel_i,
  input  logic                          frame_start_i,
  input  logic [sobel_pkg::SizeW-1:0]   width_i,
  input  logic [sobel_pkg::SizeW-1:0]   height_i,
  output logic [7:0]                    edge_o,
  output logic [sobel_pkg::CntW-1:0]    row_o,
  output logic [sobel_pkg::CntW-1:0]    col_o
);
  logic [7:0] prev_mem  [sobel_pkg::MaxWidth];
  logic [7:0] prev2_mem [sobel_pkg::MaxWidth];
  logic [7:0] top_q, mid_q, pix_q;
  logic [7:0] win_q [6];
  logic [sobel_pkg::CntW-1:0] row_q, col_q, r_q, c_q;
  logic [sobel_pkg::CntW-1:0] r_cur, c_cur;
  logic [sobel_pkg::SizeW-1:0] w_cl, h_cl;
  logic [sobel_pkg::EnergyW-1:0] energy_q;
  logic [7:0] root_q;
  logic [7:0] bit_q;
  logic       emit_q;
  logic signed [11:0] gx, gy;
  logic [21:0] ex, ey;
  logic [22:0] esum;
  logic [7:0]  trial;
  logic [15:0] tsq;

  always_comb begin
    w_cl = width_i;
    if (width_i < 12'd3) w_cl = 12'd3;
    else if (width_i > 12'(sobel_pkg::MaxWidth)) w_cl = 12'(sobel_pkg::MaxWidth);
    h_cl = height_i;
    if (height_i < 12'd3) h_cl = 12'd3;
    else if (height_i > 12'(sobel_pkg::MaxHeight)) h_cl = 12'(sobel_pkg::MaxHeight);
    r_cur = frame_start_i ? '0 : row_q;
    c_cur = frame_start_i ? '0 : col_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= pixel_i;
      r_q   <= r_cur;
      c_q   <= c_cur;
    end
    if (cmd_i.calc) begin
      prev2_mem[c_q[sobel_pkg::AddrW-1:0]] <= mid_q;
      prev_mem[c_q[sobel_pkg::AddrW-1:0]]  <= pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      top_q <= prev2_mem[c_cur[sobel_pkg::AddrW-1:0]];
      mid_q <= prev_mem[c_cur[sobel_pkg::AddrW-1:0]];
    end
  end

  always_comb begin
    gx = (12'(top_q) + {3'd0, mid_q, 1'b0} + 12'(pix_q))
       - (12'(win_q[0]) + {3'd0, win_q[1], 1'b0} + 12'(win_q[2]));
    gy = (12'(win_q[2]) + {3'd0, win_q[5], 1'b0} + 12'(pix_q))
       - (12'(win_q[0]) + {3'd0, win_q[3], 1'b0} + 12'(top_q));
    ex = 22'(gx * gx);
    ey = 22'(gy * gy);
    esum = 23'(ex) + 23'(ey);
    trial = root_q | bit_q;
    tsq = trial * trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      emit_q <= 1'b0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      if (cmd_i.load) begin
        emit_q <= (r_cur >= 11'd2) && (c_cur >= 11'd2);
        if (12'(c_cur) + 12'd1 >= w_cl) begin
          col_q <= '0;
          row_q <= (12'(r_cur) + 12'd1 >= h_cl) ? '0 : r_cur + 11'd1;
        end else begin
          col_q <= c_cur + 11'd1;
          row_q <= r_cur;
        end
      end
      if (cmd_i.calc) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top_q;
        win_q[4] <= mid_q;
        win_q[5] <= pix_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (cmd_i.root_start) begin
      bit_q <= 8'h80;
    end else if (cmd_i.root_step) begin
      bit_q <= bit_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      if (esum >= 23'd65536) energy_q <= 17'h10000;
      else energy_q <= esum[sobel_pkg::EnergyW-1:0] | {sobel_pkg::EnergyW{1'b0}};
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      if (energy_q[16]) root_q <= 8'hFF;
      else if (17'(tsq) <= energy_q) root_q <= trial;
    end
    if (cmd_i.out_load) begin
      edge_o <= root_q;
      row_o  <= r_q - 11'd1;
      col_o  <= c_q - 11'd1;
    end
  end

  assign sts_o.emit      = emit_q;
  assign sts_o.root_done = bit_q[0];
endmodule

// ===== hdl/sobel_ctrl.sv =====
// Controller state machine sequencing one pixel through the datapath.
// Depends on sobel_pkg; issues cmd_t and reads sts_t.
module sobel_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  sobel_pkg::sts_t  sts_i,
  output sobel_pkg::cmd_t  cmd_o
);
  sobel_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sobel_pkg::StIdle: if (in_valid_i) state_d = sobel_pkg::StRead;
      sobel_pkg::StRead: state_d = sobel_pkg::StCalc;
      sobel_pkg::StCalc: state_d = sts_i.emit ? sobel_pkg::StRoot : sobel_pkg::StIdle;
      sobel_pkg::StRoot: if (sts_i.root_done) state_d = sobel_pkg::StOut;
      sobel_pkg::StOut:  if (!out_valid_q || out_ready_i) state_d = sobel_pkg::StIdle;
      default:           state_d = sobel_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      sobel_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      sobel_pkg::StRead: cmd_o.calc = 1'b1;
      sobel_pkg::StCalc: cmd_o.root_start = sts_i.emit;
      sobel_pkg::StRoot: cmd_o.root_step = 1'b1;
      sobel_pkg::StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sobel_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

// ===== hdl/sobel_edge_magnitude.sv =====
// Top level of the Sobel 3x3 gradient magnitude block.
// Depends on sobel_pkg, sobel_ctrl and sobel_datapath.
//
// Pixels enter on the s_axis channel in raster order; tuser marks the first
// pixel of a frame. Each interior pixel yields one beat on m_axis holding
// the saturated gradient magnitude and its row and column; border pixels
// yield no beat. Frame size is set on the cfg channel (index 0 width,
// index 1 height), written while the block is idle.
// Each pixel takes a store read and a gradient step; one with a result then
// adds the root setup, the bit-serial root (one result bit per cycle) and
// the output load.
// The output register frees the core: a new pixel is taken while a result
// waits, and the core stalls only when a second result is ready before the
// first is taken.
// Reset clears counters, window and handshake state and loads width 1280,
// height 720; line store contents stay undefined until written.
module sobel_edge_magnitude (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel_in
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // edge_value[7:0], out_row[18:8], out_col[29:19]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);
  sobel_pkg::cmd_t cmd;
  sobel_pkg::sts_t sts;
  logic [11:0] width_q, height_q;
  logic [7:0]  edge_v;
  logic [10:0] row_v, col_v;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd1280;
      height_q <= 12'd720;
    end else if (cfg_valid) begin
      if (cfg_index == sobel_pkg::CfgWidth) width_q <= cfg_data;
      else height_q <= cfg_data;
    end
  end

  sobel_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sobel_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pixel_i      (s_axis_tdata),
    .frame_start_i(s_axis_tuser),
    .width_i      (width_q),
    .height_i     (height_q),
    .edge_o       (edge_v),
    .row_o        (row_v),
    .col_o        (col_v)
  );

  assign m_axis_tdata = {2'b00, col_v, row_v, edge_v};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.load, cmd.calc, cmd.root_start, cmd.root_step, cmd.out_load}) <= 1)
    else $error("overlapping datapath commands");
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> s_axis_tready && s_axis_tvalid)
    else $error("load without accepted beat");
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for sobel_edge_magnitude: drives pixel frames, predicts
// each interior gradient magnitude and compares result beats in order.
// Depends on sobel_pkg and the sobel_edge_magnitude RTL.
module testbench;
  typedef struct packed {
    logic [10:0] col;
    logic [10:0] row;
    logic [7:0]  edge_val;
  } edge_t;

  typedef struct {
    logic [7:0] pix;
    logic       sof;
    logic       chk;
    logic [7:0] exp_val;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = sobel_pkg::CfgWidth;
  logic [11:0] cfg_data = '0;

  sobel_edge_magnitude u_dut (.*);

  always #1 clk_i = ~clk_i;

  logic [7:0]  line1 [sobel_pkg::MaxWidth];
  logic [7:0]  line2 [sobel_pkg::MaxWidth];
  logic [7:0]  win [6];
  int unsigned row_pos, col_pos, width_reg, height_reg;
  edge_t       edge_q [$];
  int          errors, results, pixels, cycles;
  int          send_idle, recv_stall;

  function automatic int unsigned clip_size(int unsigned v, int unsigned hi);
    return v < 3 ? 3 : (v > hi ? hi : v);
  endfunction

  function automatic logic [7:0] isqrt_sat(int unsigned v);
    int unsigned r, t;
    r = 0;
    if (v >= 65536) return 8'd255;
    for (int b = 7; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= v) r = t;
    end
    return r[7:0];
  endfunction

  function automatic void predict_edge(logic [7:0] pix, logic sof);
    int unsigned w, h, c, r;
    int gx, gy;
    int top, mid;
    edge_t e;
    w = clip_size(width_reg, sobel_pkg::MaxWidth);
    h = clip_size(height_reg, sobel_pkg::MaxHeight);
    if (sof) begin
      row_pos = 0;
      col_pos = 0;
    end
    c = col_pos > sobel_pkg::MaxWidth - 1 ? sobel_pkg::MaxWidth - 1 : col_pos;
    r = row_pos;
    top = line2[c];
    mid = line1[c];
    line2[c] = mid[7:0];
    line1[c] = pix;
    if (r >= 2 && c >= 2) begin
      gx = (top + 2 * mid + pix) - (win[0] + 2 * win[1] + win[2]);
      gy = (win[2] + 2 * win[5] + pix) - (win[0] + 2 * win[3] + top);
      e.edge_val = isqrt_sat(gx * gx + gy * gy);
      e.row = 11'(r - 1);
      e.col = 11'(c - 1);
      edge_q.push_back(e);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top[7:0];
    win[4] = mid[7:0];
    win[5] = pix;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results);
    errors++;
  endtask

  // result side: random stall and compare
  always @(posedge clk_i) begin
    edge_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[29:0];
        results++;
        if (edge_q.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata[29:0], 0);
        end else begin
          want = edge_q.pop_front();
          if (got.edge_val !== want.edge_val) report_mismatch("edge", got.edge_val, want.edge_val);
          if (got.row !== want.row) report_mismatch("row", got.row, want.row);
          if (got.col !== want.col) report_mismatch("col", got.col, want.col);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [11:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == sobel_pkg::CfgWidth) width_reg = val;
    else height_reg = val;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [7:0] pix, logic sof);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    s_axis_tdata  <= pix;
    s_axis_tuser  <= sof;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_edge(pix, sof);
    pixels++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    drain();
    write_reg(sobel_pkg::CfgWidth, w[11:0]);
    write_reg(sobel_pkg::CfgHeight, h[11:0]);
  endtask

  // one full frame; pattern picks the content
  task automatic send_frame(int unsigned w, int unsigned h, int pattern);
    logic [7:0] p;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        case (pattern)
          0: p = 8'($urandom_range(255));
          1: p = (c % 2) ? 8'hff : 8'h00;
          2: p = (r == 1) ? 8'hff : 8'h00;
          default: p = $urandom_range(1) ? 8'hff : 8'h00;
        endcase
        send_pixel(p, r == 0 && c == 0);
      end
  endtask

  stim_t directed [$];
  int    pre;
  edge_t want;

  initial begin
    errors = 0; results = 0; pixels = 0; cycles = 0;
    send_idle = 0; recv_stall = 0;
    width_reg = 1280; height_reg = 720;
    row_pos = 0; col_pos = 0;
    foreach (win[i]) win[i] = '0;
    foreach (line1[i]) begin
      line1[i] = '0;
      line2[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 3x3 frames; flat gives 0, saturating step gives 255
    write_reg(sobel_pkg::CfgWidth, 12'd3);
    write_reg(sobel_pkg::CfgHeight, 12'd3);
    for (int k = 0; k < 9; k++) directed.push_back('{8'h00, k == 0, k == 8, 8'd0});
    for (int k = 0; k < 9; k++)
      directed.push_back('{(k % 3 == 2) ? 8'hff : 8'h00, k == 0, k == 8, 8'd255});
    for (int k = 0; k < 7; k++)
      directed.push_back('{8'($urandom_range(255)), k == 0 || k == 5, 1'b0, 8'd0});
    foreach (directed[i]) begin
      pre = edge_q.size();
      send_pixel(directed[i].pix, directed[i].sof);
      if (directed[i].chk) begin
        want = edge_q[edge_q.size() - 1];
        if (edge_q.size() != pre + 1 || want.edge_val != directed[i].exp_val)
          report_mismatch("directed", want.edge_val, directed[i].exp_val);
      end
    end

    // out-of-range sizes below the minimum act as 3
    set_size(0, 2);
    send_frame(3, 3, 3);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 23 : 46) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 23 : 46) : 0;
      set_size($urandom_range(3, 12), $urandom_range(3, 8));
      for (int f = 0; f < 8; f++) send_frame(width_reg, height_reg, f);
      drain();
      // stray frame_start midway through a frame
      for (int k = 0; k < 40; k++)
        send_pixel(8'($urandom_range(255)), $urandom_range(15) == 0);
    end
    send_idle = 0; recv_stall = 0;
    set_size(1280, 720);
    send_frame(3, 3, 0);

    drain();
    $display("covered %0d pixels and %0d result beats over sizes 3x3 to 12x8", pixels, results);
    $display("with sender gaps and receiver stalls up to 46 percent");
    if (errors == 0 && edge_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/sobel_pkg.sv
hdl/sobel_datapath.sv
hdl/sobel_ctrl.sv
hdl/sobel_edge_magnitude.sv
dv/testbench.sv
